@@ rtl/core/wta_pkg.sv @@
// shared types and constants of the wav to aiff stream converter
// no dependencies; used by front, queue, back and top level
package wta_pkg;

    // width of an accepted sample rate
    localparam int RATE_BITS = 20;

    // header tags as they appear little-endian in the shift word
    localparam logic [31:0] TAG_RIFF_LE = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE_LE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT_LE  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA_LE = 32'h6174_6164;

    // aiff tags and sizes
    localparam logic [31:0] TAG_FORM  = 32'h464F_524D;
    localparam logic [31:0] TAG_AIFF  = 32'h4149_4646;
    localparam logic [31:0] TAG_COMM  = 32'h434F_4D4D;
    localparam logic [31:0] TAG_SSND  = 32'h5353_4E44;
    localparam logic [31:0] FMT_SIZE  = 32'd16;
    localparam logic [31:0] COMM_SIZE = 32'd18;
    localparam logic [5:0]  HDR_LAST_IN  = 6'd43;
    localparam logic [5:0]  HDR_LAST_OUT = 6'd53;

    // result status codes
    localparam logic [3:0] ST_DATA     = 4'd0;
    localparam logic [3:0] ST_END      = 4'd1;
    localparam logic [3:0] ST_RIFF     = 4'd2;
    localparam logic [3:0] ST_WAVE     = 4'd3;
    localparam logic [3:0] ST_FMT_TAG  = 4'd4;
    localparam logic [3:0] ST_FMT_SIZE = 4'd5;
    localparam logic [3:0] ST_NOT_PCM  = 4'd6;
    localparam logic [3:0] ST_CHANNELS = 4'd7;
    localparam logic [3:0] ST_RATE     = 4'd8;
    localparam logic [3:0] ST_WIDTH    = 4'd9;
    localparam logic [3:0] ST_DATA_TAG = 4'd10;
    localparam logic [3:0] ST_TRUNC    = 4'd11;

    // command kinds from front to back
    localparam logic [1:0] CMD_HDR  = 2'd0;
    localparam logic [1:0] CMD_SAMP = 2'd1;
    localparam logic [1:0] CMD_TAIL = 2'd2;

    // one command in the queue
    typedef struct packed {
        logic [1:0]           kind;
        logic                 eos;
        logic [3:0]           code;
        logic [31:0]          word;   // data byte count or sample bytes, first out lowest
        logic [2:0]           cnt;    // sample bytes to emit
        logic [1:0]           ch;
        logic [2:0]           wb;
        logic [RATE_BITS-1:0] rate;
    } cmd_t;

endpackage

@@ rtl/core/wta_front.sv @@
// front part: header parser and sample gatherer, one command per result-bearing byte
// depends on wta_pkg
module wta_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          end_of_stream,
    output logic          push,
    output wta_pkg::cmd_t cmd
);
    import wta_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_DROP   = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [5:0]           pos_reg, pos_next;
    logic [31:0]          shift_reg, shift_next;
    logic [1:0]           ch_reg, ch_next;
    logic [RATE_BITS-1:0] rate_reg, rate_next;
    logic [2:0]           wb_reg, wb_next;
    logic [23:0]          hold_reg, hold_next;
    logic [1:0]           fill_reg, fill_next;

    logic [31:0] sh;
    logic [15:0] v16;
    logic [3:0]  code;
    logic        done;

    assign sh   = {in_byte, shift_reg[31:8]};
    assign v16  = sh[31:16];
    assign done = ({1'b0, fill_reg} + 3'd1) >= wb_reg;

    // header checks by position
    always_comb
    begin
        code      = ST_DATA;
        ch_next   = ch_reg;
        rate_next = rate_reg;
        wb_next   = wb_reg;
        unique case (pos_reg)
            6'd3:  if (sh != TAG_RIFF_LE) code = ST_RIFF;
            6'd11: if (sh != TAG_WAVE_LE) code = ST_WAVE;
            6'd15: if (sh != TAG_FMT_LE) code = ST_FMT_TAG;
            6'd19: if (sh != FMT_SIZE) code = ST_FMT_SIZE;
            6'd21: if (v16 != 16'd1) code = ST_NOT_PCM;
            6'd23:
            begin
                if (v16 == 16'd1 || v16 == 16'd2) ch_next = v16[1:0];
                else code = ST_CHANNELS;
            end
            6'd27:
            begin
                if (sh == 32'd0 || sh[31:RATE_BITS] != '0) code = ST_RATE;
                else rate_next = sh[RATE_BITS-1:0];
            end
            6'd35:
            begin
                if (v16 == 16'd16) wb_next = 3'd2;
                else if (v16 == 16'd24) wb_next = 3'd3;
                else if (v16 == 16'd32) wb_next = 3'd4;
                else code = ST_WIDTH;
            end
            6'd39: if (sh != TAG_DATA_LE) code = ST_DATA_TAG;
            default: ;
        endcase
    end

    // next state and command
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        hold_next  = hold_reg;
        fill_next  = fill_reg;
        push       = 1'b0;
        cmd        = '0;
        cmd.eos    = end_of_stream;
        cmd.ch     = ch_next;
        cmd.wb     = wb_next;
        cmd.rate   = rate_next;
        unique case (phase_reg)
            PH_HEADER:
            begin
                shift_next = sh;
                if (code != ST_DATA)
                begin
                    push       = 1'b1;
                    cmd.kind   = CMD_TAIL;
                    cmd.code   = code;
                    phase_next = PH_DROP;
                end
                else if (pos_reg >= HDR_LAST_IN)
                begin
                    push       = 1'b1;
                    cmd.kind   = CMD_HDR;
                    cmd.word   = sh;
                    phase_next = PH_DATA;
                    hold_next  = '0;
                    fill_next  = '0;
                end
                else
                begin
                    pos_next = pos_reg + 6'd1;
                    if (end_of_stream)
                    begin
                        push     = 1'b1;
                        cmd.kind = CMD_TAIL;
                        cmd.code = ST_TRUNC;
                    end
                end
            end
            PH_DATA:
            begin
                if (done)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_SAMP;
                    cmd.cnt  = {1'b0, fill_reg} + 3'd1;
                    case (fill_reg)
                        2'd0: cmd.word = {24'd0, in_byte};
                        2'd1: cmd.word = {16'd0, hold_reg[7:0], in_byte};
                        2'd2: cmd.word = {8'd0, hold_reg[7:0], hold_reg[15:8], in_byte};
                        default: cmd.word = {hold_reg[7:0], hold_reg[15:8],
                                             hold_reg[23:16], in_byte};
                    endcase
                    hold_next = '0;
                    fill_next = '0;
                end
                else
                begin
                    case (fill_reg)
                        2'd0: hold_next = {hold_reg[23:8], in_byte};
                        2'd1: hold_next = {hold_reg[23:16], in_byte, hold_reg[7:0]};
                        default: hold_next = {in_byte, hold_reg[15:0]};
                    endcase
                    fill_next = fill_reg + 2'd1;
                    if (end_of_stream)
                    begin
                        push     = 1'b1;
                        cmd.kind = CMD_TAIL;
                        cmd.code = ST_END;
                    end
                end
            end
            default: ;
        endcase
        push = push & accept;
    end

    // state registers, back to reset at end of stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            shift_reg <= '0;
            ch_reg    <= '0;
            rate_reg  <= '0;
            wb_reg    <= '0;
            hold_reg  <= '0;
            fill_reg  <= '0;
        end
        else if (accept)
        begin
            if (end_of_stream)
            begin
                phase_reg <= PH_HEADER;
                pos_reg   <= '0;
                shift_reg <= '0;
                ch_reg    <= '0;
                rate_reg  <= '0;
                wb_reg    <= '0;
                hold_reg  <= '0;
                fill_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                shift_reg <= shift_next;
                ch_reg    <= ch_next;
                rate_reg  <= rate_next;
                wb_reg    <= wb_next;
                hold_reg  <= hold_next;
                fill_reg  <= fill_next;
            end
        end
    end

endmodule

@@ rtl/core/wta_queue.sv @@
// two-entry command queue between front and back
// depends on wta_pkg
module wta_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wta_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output wta_pkg::cmd_t head
);
    import wta_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign valid = cnt_reg != 2'd0;
    assign head  = mem_reg[rp_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

endmodule

@@ rtl/core/wta_back.sv @@
// back part: expands commands into aiff bytes, with serial divider and rate normalizer
// depends on wta_pkg
module wta_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  wta_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    out_byte,
    output logic [3:0]    status,
    output logic          run_last,
    output logic          file_last
);
    import wta_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_CALC = 3'd1;
    localparam logic [2:0] B_HDR  = 3'd2;
    localparam logic [2:0] B_SAMP = 3'd3;
    localparam logic [2:0] B_TAIL = 3'd4;
    localparam int EXP_BITS = $clog2(RATE_BITS);

    logic [2:0]          state_reg, state_next;
    logic [5:0]          idx_reg, idx_next;
    cmd_t                cur_reg;
    logic [3:0]          tail_reg, tail_next;
    logic [31:0]         form_reg, ssnd_reg;
    logic [31:0]         quo_reg;
    logic [3:0]          rem_reg;
    logic [63:0]         mant_reg;
    logic [EXP_BITS-1:0] exp_reg;

    logic        ov_reg, rl_reg, fl_reg;
    logic [7:0]  ob_reg;
    logic [3:0]  os_reg;

    logic        free, emit, e_rl, e_fl;
    logic [7:0]  e_byte;
    logic [3:0]  e_st;
    logic [3:0]  block;
    logic [4:0]  rtry;
    logic [431:0] hdr;
    logic [5:0]  sel;
    logic [15:0] exv;

    assign free  = !ov_reg || m_tready;
    assign block = 4'({2'b0, cur_reg.ch} * {1'b0, cur_reg.wb});
    assign rtry  = {rem_reg, quo_reg[31]};
    assign exv   = 16'h3FFF + 16'(exp_reg);
    assign hdr   = {TAG_FORM, form_reg, TAG_AIFF, TAG_COMM, COMM_SIZE,
                    14'd0, cur_reg.ch, quo_reg, 10'd0, cur_reg.wb, 3'd0,
                    exv, mant_reg, TAG_SSND, ssnd_reg, 64'd0};
    assign sel   = HDR_LAST_OUT - idx_reg;
    assign q_pop = (state_reg == B_IDLE) && q_valid;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        tail_next  = tail_reg;
        emit       = 1'b0;
        e_byte     = '0;
        e_st       = ST_DATA;
        e_rl       = 1'b0;
        e_fl       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                idx_next = '0;
                if (q_valid)
                begin
                    tail_next = ST_END;
                    unique case (q_head.kind)
                        CMD_HDR:  state_next = B_CALC;
                        CMD_SAMP: state_next = B_SAMP;
                        default:
                        begin
                            state_next = B_TAIL;
                            tail_next  = q_head.code;
                        end
                    endcase
                end
            end
            B_CALC:
            begin
                idx_next = idx_reg + 6'd1;
                if (idx_reg == 6'd31)
                begin
                    idx_next   = '0;
                    state_next = B_HDR;
                end
            end
            B_HDR:
            begin
                if (free)
                begin
                    emit     = 1'b1;
                    e_byte   = hdr[{sel, 3'b0} +: 8];
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == HDR_LAST_OUT)
                    begin
                        e_rl       = !cur_reg.eos;
                        state_next = cur_reg.eos ? B_TAIL : B_IDLE;
                    end
                end
            end
            B_SAMP:
            begin
                if (free)
                begin
                    emit     = 1'b1;
                    e_byte   = cur_reg.word[{idx_reg[1:0], 3'b0} +: 8];
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg[2:0] == cur_reg.cnt - 3'd1)
                    begin
                        e_rl       = !cur_reg.eos;
                        state_next = cur_reg.eos ? B_TAIL : B_IDLE;
                    end
                end
            end
            B_TAIL:
            begin
                if (free)
                begin
                    emit       = 1'b1;
                    e_st       = tail_reg;
                    e_rl       = 1'b1;
                    e_fl       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (emit) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    // command, divider and normalizer datapath
    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        if (q_pop)
        begin
            cur_reg  <= q_head;
            form_reg <= q_head.word + 32'd46;
            ssnd_reg <= q_head.word + 32'd8;
            quo_reg  <= q_head.word;
            rem_reg  <= '0;
            mant_reg <= {q_head.rate, (64 - RATE_BITS)'(0)};
            exp_reg  <= EXP_BITS'(RATE_BITS - 1);
        end
        else if (state_reg == B_CALC)
        begin
            // one quotient bit per cycle
            if (rtry >= {1'b0, block})
            begin
                rem_reg <= 4'(rtry - {1'b0, block});
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rtry[3:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            // one normalizing shift per cycle
            if (!mant_reg[63] && mant_reg != '0)
            begin
                mant_reg <= {mant_reg[62:0], 1'b0};
                exp_reg  <= exp_reg - EXP_BITS'(1);
            end
        end
        if (emit)
        begin
            ob_reg <= e_byte;
            os_reg <= e_st;
            rl_reg <= e_rl;
            fl_reg <= e_fl;
        end
    end

    assign m_tvalid  = ov_reg;
    assign out_byte  = ob_reg;
    assign status    = os_reg;
    assign run_last  = rl_reg;
    assign file_last = fl_reg;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_tready |=> ov_reg && $stable(ob_reg) && $stable(os_reg))
        else $error("result changed while stalled");
    a_file_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && fl_reg |-> rl_reg && os_reg != ST_DATA)
        else $error("file end without run end");
    a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_HDR |-> idx_reg <= HDR_LAST_OUT)
        else $error("header index past end");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != B_IDLE)
        else $error("command popped but not started");

endmodule

@@ rtl/core/wav_to_aiff_stream_converter_core.sv @@
// top level of the wav to aiff stream converter
// depends on wta_pkg, wta_front, wta_queue, wta_back
//
// channel   direction  tdata                   tuser                     tlast
// s_*       in         [7:0] in_byte           -                         end_of_stream
// m_*       out        [7:0] out_byte          [3:0] status, [4] run_last file_last
//
// input bytes are taken one per cycle while the two-entry command queue has room
// a data sample leaves at one byte per cycle unless stalled; a header divides, then 54 bytes
// the frame count divider and rate normalizer in the back part set the header latency
// output stalls fill the queue and then hold off input; asynchronous active-low reset
module wav_to_aiff_stream_converter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [4:0] m_tuser,   // [3:0] status, [4] run_last
    output logic       m_tlast
);
    import wta_pkg::*;

    logic accept, push, full, q_valid, q_pop, rl;
    logic [3:0] st;
    cmd_t cmd, head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    wta_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (s_tdata),
        .end_of_stream (s_tlast),
        .push          (push),
        .cmd           (cmd)
    );

    wta_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (q_pop),
        .full     (full),
        .valid    (q_valid),
        .head     (head)
    );

    wta_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_byte  (m_tdata),
        .status    (st),
        .run_last  (rl),
        .file_last (m_tlast)
    );

    assign m_tuser = {rl, st};

endmodule
